// ===== rtl/spd_pkg.sv =====
// Shared types, codes and constants of the scene presence detector.
`timescale 1ns / 1ps

package spd_pkg;

   // Configuration port geometry.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 32;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DETECT_SCORE       = 3'd0,
      CSR_STRONG_SCORE       = 3'd1,
      CSR_RETAIN_WINDOW_MS   = 3'd2,
      CSR_DETECT_DWELL_MS    = 3'd3,
      CSR_LOST_DWELL_MS      = 3'd4,
      CSR_MIN_STABLE_SAMPLES = 3'd5
   } spd_csr_index_type;

   // Reset values of the configuration registers.
   localparam logic [6:0]  DETECT_SCORE_RST       = 7'd55;
   localparam logic [6:0]  STRONG_SCORE_RST       = 7'd60;
   localparam logic [31:0] RETAIN_WINDOW_MS_RST   = 32'd2500;
   localparam logic [31:0] DETECT_DWELL_MS_RST    = 32'd300;
   localparam logic [31:0] LOST_DWELL_MS_RST      = 32'd120000;
   localparam logic [15:0] MIN_STABLE_SAMPLES_RST = 16'd2;

   // Scene classification thresholds.
   localparam logic [7:0] FLAT_CONTRAST_MAX = 8'd18;
   localparam logic [7:0] DARK_LUMA_MAX     = 8'd45;
   localparam logic [7:0] DIM_LUMA_MAX      = 8'd90;
   localparam logic [7:0] BRIGHT_LUMA_MIN   = 8'd210;

   // Presence score constants.
   localparam logic [7:0] SCORE_MAX         = 8'd100;
   localparam logic [7:0] MOTION_KNEE       = 8'd30;
   localparam logic [7:0] MOTION_CAP_SCORE  = 8'd60;
   localparam logic [7:0] CONTRAST_FLOOR    = 8'd24;
   localparam logic [7:0] CONTRAST_KNEE     = 8'd84;
   localparam logic [7:0] CONTRAST_CAP      = 8'd25;
   localparam logic [7:0] LUMA_BONUS        = 8'd15;
   // Multiply by 171 and shift by 9 divides values up to 60 exactly by 3.
   localparam logic [7:0] DIV3_RECIP        = 8'd171;
   localparam int unsigned DIV3_SHIFT       = 9;

   typedef enum logic [2:0] {
      SCENE_UNKNOWN = 3'd0,
      SCENE_DARK    = 3'd1,
      SCENE_DIM     = 3'd2,
      SCENE_NORMAL  = 3'd3,
      SCENE_BRIGHT  = 3'd4,
      SCENE_FLAT    = 3'd5
   } spd_scene_type;

   typedef struct packed {
      logic        sample_valid;
      logic [7:0]  luma_mean;
      logic [7:0]  frame_contrast;
      logic [7:0]  motion_level;
      logic [31:0] time_ms;
   } spd_req_type;

   typedef struct packed {
      logic [2:0]  scene_class;
      logic [6:0]  score_out;
      logic [1:0]  presence_state;
      logic [1:0]  event_kind;
      logic [6:0]  ev_score_out;
      logic [31:0] transitions;
      logic [31:0] detected_events;
      logic [31:0] lost_events;
      logic [31:0] last_transition_time;
   } spd_rsp_type;

   typedef struct packed {
      logic [6:0]  detect_score;
      logic [6:0]  strong_score;
      logic [31:0] retain_window_ms;
      logic [31:0] detect_dwell_ms;
      logic [31:0] lost_dwell_ms;
      logic [15:0] min_stable_samples;
   } spd_cfg_type;

endpackage

// ===== rtl/spd_csr.sv =====
// Configuration register file of the scene presence detector.
`timescale 1ns / 1ps

module spd_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              wr_en,
   input  logic [spd_pkg::CSR_INDEX_W-1:0]   wr_index,
   input  logic [spd_pkg::CSR_DATA_W-1:0]    wr_data,
   output spd_pkg::spd_cfg_type              cfg
);
   import spd_pkg::*;

   spd_cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.detect_score       <= DETECT_SCORE_RST;
         cfg_ff.strong_score       <= STRONG_SCORE_RST;
         cfg_ff.retain_window_ms   <= RETAIN_WINDOW_MS_RST;
         cfg_ff.detect_dwell_ms    <= DETECT_DWELL_MS_RST;
         cfg_ff.lost_dwell_ms      <= LOST_DWELL_MS_RST;
         cfg_ff.min_stable_samples <= MIN_STABLE_SAMPLES_RST;
      end else if (wr_en) begin
         case (spd_csr_index_type'(wr_index))
            CSR_DETECT_SCORE:       cfg_ff.detect_score       <= wr_data[6:0];
            CSR_STRONG_SCORE:       cfg_ff.strong_score       <= wr_data[6:0];
            CSR_RETAIN_WINDOW_MS:   cfg_ff.retain_window_ms   <= wr_data[31:0];
            CSR_DETECT_DWELL_MS:    cfg_ff.detect_dwell_ms    <= wr_data[31:0];
            CSR_LOST_DWELL_MS:      cfg_ff.lost_dwell_ms      <= wr_data[31:0];
            CSR_MIN_STABLE_SAMPLES: cfg_ff.min_stable_samples <= wr_data[15:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/spd_score.sv =====
// Scene classification and presence score of one metrics sample.
`timescale 1ns / 1ps

module spd_score (
   input  spd_pkg::spd_req_type   sample,
   output spd_pkg::spd_scene_type scene,
   output logic [6:0]             score
);
   import spd_pkg::*;

   logic [7:0]  motion_part;
   logic [5:0]  contrast_excess;
   logic [13:0] contrast_prod;
   logic [7:0]  contrast_part;
   logic [7:0]  luma_part;
   logic [7:0]  sum;
   logic [7:0]  capped_motion;

   always_comb begin
      if (!sample.sample_valid) begin
         scene = SCENE_UNKNOWN;
      end else if (sample.frame_contrast < FLAT_CONTRAST_MAX) begin
         scene = SCENE_FLAT;
      end else if (sample.luma_mean < DARK_LUMA_MAX) begin
         scene = SCENE_DARK;
      end else if (sample.luma_mean < DIM_LUMA_MAX) begin
         scene = SCENE_DIM;
      end else if (sample.luma_mean > BRIGHT_LUMA_MIN) begin
         scene = SCENE_BRIGHT;
      end else begin
         scene = SCENE_NORMAL;
      end
   end

   always_comb begin
      motion_part = (sample.motion_level > MOTION_KNEE) ? MOTION_CAP_SCORE
                                                        : {sample.motion_level[6:0], 1'b0};
      // Only the range between the floor and the knee reaches the divider.
      contrast_excess = 6'((sample.frame_contrast - CONTRAST_FLOOR));
      contrast_prod   = 14'(contrast_excess) * 14'(DIV3_RECIP);
      if (sample.frame_contrast < CONTRAST_FLOOR) begin
         contrast_part = 8'd0;
      end else if (sample.frame_contrast > CONTRAST_KNEE) begin
         contrast_part = CONTRAST_CAP;
      end else begin
         contrast_part = 8'(contrast_prod >> DIV3_SHIFT);
      end
      luma_part = (sample.luma_mean >= DARK_LUMA_MAX && sample.luma_mean <= BRIGHT_LUMA_MIN)
                  ? LUMA_BONUS : 8'd0;
      sum           = motion_part + contrast_part + luma_part;
      capped_motion = (sample.motion_level > SCORE_MAX) ? SCORE_MAX : sample.motion_level;

      if (!sample.sample_valid) begin
         score = 7'd0;
      end else if (scene inside {SCENE_UNKNOWN, SCENE_DARK, SCENE_FLAT}) begin
         score = capped_motion[6:0];
      end else if (sum > SCORE_MAX) begin
         score = SCORE_MAX[6:0];
      end else begin
         score = sum[6:0];
      end
   end

endmodule

// ===== rtl/spd_fsm.sv =====
// Presence state machine, dwell timing and event counters.
`timescale 1ns / 1ps

module spd_fsm (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   upd,
   input  logic [31:0]            now,
   input  spd_pkg::spd_scene_type scene,
   input  logic [6:0]             score,
   input  spd_pkg::spd_cfg_type   cfg,
   output spd_pkg::spd_rsp_type   rsp
);
   import spd_pkg::*;

   typedef enum logic [1:0] {
      PRES_ABSENT    = 2'd0,
      PRES_CANDIDATE = 2'd1,
      PRES_PRESENT   = 2'd2
   } pres_state_type;

   typedef enum logic [1:0] {
      EV_NONE     = 2'd0,
      EV_DETECTED = 2'd1,
      EV_LOST     = 2'd2
   } event_kind_type;

   pres_state_type pres_ff, pres_in;
   logic [6:0]     prev_score_ff, prev_score_in;
   logic [31:0]    cand_start_ff, cand_start_in;
   logic [31:0]    abs_start_ff, abs_start_in;
   logic [15:0]    stable_ff, stable_in;
   logic [15:0]    abs_count_ff, abs_count_in;
   logic [31:0]    trans_total_ff, trans_total_in;
   logic [31:0]    det_total_ff, det_total_in;
   logic [31:0]    lost_total_ff, lost_total_in;
   logic [31:0]    trans_time_ff, trans_time_in;

   logic           raw, retained;
   logic [31:0]    cand_base, cand_age, abs_base, abs_age;
   event_kind_type ev_kind;
   logic [6:0]     ev_score;

   always_comb begin
      raw       = (score >= cfg.detect_score);
      cand_base = (cand_start_ff == 32'd0) ? now : cand_start_ff;
      cand_age  = now - cand_base;
      abs_base  = (abs_start_ff == 32'd0) ? now : abs_start_ff;
      abs_age   = now - abs_base;
      retained  = !raw && pres_ff == PRES_CANDIDATE && cand_start_ff != 32'd0 &&
                  prev_score_ff >= cfg.strong_score && cand_age <= cfg.retain_window_ms;

      pres_in        = pres_ff;
      prev_score_in  = score;
      cand_start_in  = cand_start_ff;
      abs_start_in   = abs_start_ff;
      stable_in      = stable_ff;
      abs_count_in   = abs_count_ff;
      trans_total_in = trans_total_ff;
      det_total_in   = det_total_ff;
      lost_total_in  = lost_total_ff;
      trans_time_in  = trans_time_ff;
      ev_kind        = EV_NONE;
      ev_score       = 7'd0;

      if (raw || retained) begin
         cand_start_in = cand_base;
         abs_start_in  = 32'd0;
         abs_count_in  = 16'd0;
         if (raw && stable_ff != 16'hFFFF) begin
            stable_in = stable_ff + 16'd1;
         end
         if (pres_ff != PRES_PRESENT && raw && stable_in >= cfg.min_stable_samples &&
             cand_age >= cfg.detect_dwell_ms) begin
            pres_in        = PRES_PRESENT;
            trans_time_in  = now;
            trans_total_in = trans_total_ff + 32'd1;
            det_total_in   = det_total_ff + 32'd1;
            ev_kind        = EV_DETECTED;
            ev_score       = score;
         end else if (pres_ff != PRES_PRESENT) begin
            pres_in = PRES_CANDIDATE;
         end
      end else begin
         abs_start_in  = abs_base;
         cand_start_in = 32'd0;
         stable_in     = 16'd0;
         if (abs_count_ff != 16'hFFFF) begin
            abs_count_in = abs_count_ff + 16'd1;
         end
         if (pres_ff == PRES_PRESENT && abs_age >= cfg.lost_dwell_ms) begin
            pres_in        = PRES_ABSENT;
            trans_time_in  = now;
            trans_total_in = trans_total_ff + 32'd1;
            lost_total_in  = lost_total_ff + 32'd1;
            ev_kind        = EV_LOST;
            ev_score       = score;
         end else if (pres_ff != PRES_PRESENT) begin
            pres_in = PRES_ABSENT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pres_ff        <= PRES_ABSENT;
         prev_score_ff  <= 7'd0;
         cand_start_ff  <= 32'd0;
         abs_start_ff   <= 32'd0;
         stable_ff      <= 16'd0;
         abs_count_ff   <= 16'd0;
         trans_total_ff <= 32'd0;
         det_total_ff   <= 32'd0;
         lost_total_ff  <= 32'd0;
         trans_time_ff  <= 32'd0;
      end else if (upd) begin
         pres_ff        <= pres_in;
         prev_score_ff  <= prev_score_in;
         cand_start_ff  <= cand_start_in;
         abs_start_ff   <= abs_start_in;
         stable_ff      <= stable_in;
         abs_count_ff   <= abs_count_in;
         trans_total_ff <= trans_total_in;
         det_total_ff   <= det_total_in;
         lost_total_ff  <= lost_total_in;
         trans_time_ff  <= trans_time_in;
      end
   end

   always_comb begin
      rsp.scene_class          = scene;
      rsp.score_out            = score;
      rsp.presence_state       = pres_in;
      rsp.event_kind           = ev_kind;
      rsp.ev_score_out         = ev_score;
      rsp.transitions          = trans_total_in;
      rsp.detected_events      = det_total_in;
      rsp.lost_events          = lost_total_in;
      rsp.last_transition_time = trans_time_in;
   end

   // A detected event always leaves the machine in the present state.
   assert property (@(posedge clock) disable iff (reset)
      upd && ev_kind == EV_DETECTED |=> pres_ff == PRES_PRESENT)
      else $error("detected event without entering present state");

   // State only moves when a transaction is processed.
   assert property (@(posedge clock) disable iff (reset)
      !upd |=> $stable(pres_ff) && $stable(trans_total_ff))
      else $error("presence state changed without a transaction");

   // Every event bumps the transition count by exactly one.
   assert property (@(posedge clock) disable iff (reset)
      upd && ev_kind != EV_NONE |=> trans_total_ff == $past(trans_total_ff) + 32'd1)
      else $error("transition count not advanced on event");

   // Candidate and absence runs are mutually exclusive.
   assert property (@(posedge clock) disable iff (reset)
      stable_ff != 16'd0 |-> abs_count_ff == 16'd0)
      else $error("stable and absent counts both running");

endmodule

// ===== rtl/scene_presence_detector_top.sv =====
// Top level of the scene presence detector: handshakes, sample register and result register.
`timescale 1ns / 1ps

// A request transaction accepted into the sample register is processed into the result
// register, where rsp_valid rises; this waits while the result register is full and stalled.
// One transaction per cycle while the result channel is not stalled; the score and the state
// update are combinational between the sample register and the result register.
// Reset is synchronous and active high; it restores the register defaults, returns the
// machine to absent, clears all counters and empties both pipeline registers.
module scene_presence_detector_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  spd_pkg::spd_req_type            req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output spd_pkg::spd_rsp_type            rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [spd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [spd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import spd_pkg::*;

   // Sample register holding the accepted request transaction.
   spd_req_type req_ff;
   logic        req_valid_ff;
   // Result register; it decouples the response side from the request side.
   spd_rsp_type rsp_ff;
   logic        rsp_valid_ff;

   logic          out_free;
   logic          adv;
   spd_cfg_type   cfg;
   spd_scene_type scene;
   logic [6:0]    score;
   spd_rsp_type   rsp_next;

   // The result register can take a new result when it is empty or being drained this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // A held sample is processed, and the state machine advances, when it can move onward.
   assign adv       = req_valid_ff && out_free;
   // The sample register stalls the request side only when its occupant cannot move.
   assign req_stall = req_valid_ff && !out_free;
   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   spd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   spd_score u_score (
      .sample (req_ff),
      .scene  (scene),
      .score  (score)
   );

   spd_fsm u_fsm (
      .clock (clock),
      .reset (reset),
      .upd   (adv),
      .now   (req_ff.time_ms),
      .scene (scene),
      .score (score),
      .cfg   (cfg),
      .rsp   (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== bench/spd_presence_checker.sv =====
// Checker for the scene presence detector: predicts each result and compares it.
`timescale 1ns / 1ps

module spd_presence_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  spd_pkg::spd_req_type            req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  spd_pkg::spd_rsp_type            rsp_data,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [spd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [spd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              mismatch_count,
   output int                              pending_count
);
   import spd_pkg::*;

   typedef enum logic [1:0] {
      OCC_ABSENT    = 2'd0,
      OCC_CANDIDATE = 2'd1,
      OCC_PRESENT   = 2'd2
   } occupancy_type;

   typedef enum logic [1:0] {
      EVT_NONE     = 2'd0,
      EVT_DETECTED = 2'd1,
      EVT_LOST     = 2'd2
   } presence_event_type;

   spd_cfg_type   cfg;
   occupancy_type occupancy;
   logic [6:0]    last_score;
   logic [31:0]   candidate_since;
   logic [31:0]   absent_since;
   logic [15:0]   raw_run;
   logic [15:0]   absent_run;
   logic [31:0]   transition_total;
   logic [31:0]   detected_total;
   logic [31:0]   lost_total;
   logic [31:0]   transition_stamp;

   spd_rsp_type   expected_rsp_q[$];
   int            failures;
   int            results_seen;

   function automatic spd_scene_type scene_of_sample(spd_req_type s);
      if (!s.sample_valid) return SCENE_UNKNOWN;
      if (s.frame_contrast < FLAT_CONTRAST_MAX) return SCENE_FLAT;
      if (s.luma_mean < DARK_LUMA_MAX) return SCENE_DARK;
      if (s.luma_mean < DIM_LUMA_MAX) return SCENE_DIM;
      if (s.luma_mean > BRIGHT_LUMA_MIN) return SCENE_BRIGHT;
      return SCENE_NORMAL;
   endfunction

   function automatic logic [6:0] score_of_sample(spd_req_type s, spd_scene_type scene);
      int unsigned total;
      if (!s.sample_valid) return 7'd0;
      // Unknown, dark and flat scenes score on motion alone.
      if (scene == SCENE_UNKNOWN || scene == SCENE_DARK || scene == SCENE_FLAT)
         return (s.motion_level > SCORE_MAX) ? SCORE_MAX[6:0] : s.motion_level[6:0];
      total = (s.motion_level > MOTION_KNEE) ? int'(MOTION_CAP_SCORE)
                                             : int'(s.motion_level) * 2;
      if (s.frame_contrast >= CONTRAST_FLOOR) begin
         if (s.frame_contrast > CONTRAST_KNEE)
            total += CONTRAST_CAP;
         else
            total += (int'(s.frame_contrast) - int'(CONTRAST_FLOOR)) / 3;
      end
      if (s.luma_mean >= DARK_LUMA_MAX && s.luma_mean <= BRIGHT_LUMA_MIN)
         total += LUMA_BONUS;
      return (total > SCORE_MAX) ? SCORE_MAX[6:0] : total[6:0];
   endfunction

   // Advances the presence machine by one sample and returns the result it should give.
   function automatic spd_rsp_type advance_presence(spd_req_type s);
      spd_scene_type      scene;
      logic [6:0]         score;
      logic               raw;
      logic               retained;
      logic [31:0]        age;
      presence_event_type ev;
      logic [6:0]         ev_score;
      spd_rsp_type        r;

      scene    = scene_of_sample(s);
      score    = score_of_sample(s, scene);
      ev       = EVT_NONE;
      ev_score = 7'd0;
      raw      = (score >= cfg.detect_score);
      age      = s.time_ms - candidate_since;
      retained = !raw && occupancy == OCC_CANDIDATE && candidate_since != 32'd0 &&
                 last_score >= cfg.strong_score && age <= cfg.retain_window_ms;
      last_score = score;

      if (raw || retained) begin
         // A start stamp of zero means the candidate run has not started yet.
         if (candidate_since == 32'd0) candidate_since = s.time_ms;
         absent_since = 32'd0;
         absent_run   = 16'd0;
         if (raw && raw_run != 16'hFFFF) raw_run++;
         age = s.time_ms - candidate_since;
         if (occupancy != OCC_PRESENT && raw && raw_run >= cfg.min_stable_samples &&
             age >= cfg.detect_dwell_ms) begin
            occupancy        = OCC_PRESENT;
            transition_stamp = s.time_ms;
            transition_total++;
            detected_total++;
            ev       = EVT_DETECTED;
            ev_score = score;
         end else if (occupancy != OCC_PRESENT) begin
            occupancy = OCC_CANDIDATE;
         end
      end else begin
         if (absent_since == 32'd0) absent_since = s.time_ms;
         candidate_since = 32'd0;
         raw_run         = 16'd0;
         if (absent_run != 16'hFFFF) absent_run++;
         age = s.time_ms - absent_since;
         if (occupancy == OCC_PRESENT && age >= cfg.lost_dwell_ms) begin
            occupancy        = OCC_ABSENT;
            transition_stamp = s.time_ms;
            transition_total++;
            lost_total++;
            ev       = EVT_LOST;
            ev_score = score;
         end else if (occupancy != OCC_PRESENT) begin
            occupancy = OCC_ABSENT;
         end
      end

      r.scene_class          = scene;
      r.score_out            = score;
      r.presence_state       = occupancy;
      r.event_kind           = ev;
      r.ev_score_out         = ev_score;
      r.transitions          = transition_total;
      r.detected_events      = detected_total;
      r.lost_events          = lost_total;
      r.last_transition_time = transition_stamp;
      return r;
   endfunction

   always @(posedge clock) begin
      spd_rsp_type want;
      if (reset) begin
         cfg.detect_score       = DETECT_SCORE_RST;
         cfg.strong_score       = STRONG_SCORE_RST;
         cfg.retain_window_ms   = RETAIN_WINDOW_MS_RST;
         cfg.detect_dwell_ms    = DETECT_DWELL_MS_RST;
         cfg.lost_dwell_ms      = LOST_DWELL_MS_RST;
         cfg.min_stable_samples = MIN_STABLE_SAMPLES_RST;
         occupancy        = OCC_ABSENT;
         last_score       = 7'd0;
         candidate_since  = 32'd0;
         absent_since     = 32'd0;
         raw_run          = 16'd0;
         absent_run       = 16'd0;
         transition_total = 32'd0;
         detected_total   = 32'd0;
         lost_total       = 32'd0;
         transition_stamp = 32'd0;
         expected_rsp_q.delete();
         failures     = 0;
         results_seen = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_rsp_q.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("mismatch %0d: result %0d arrived with nothing expected",
                           failures, results_seen);
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_data !== want) begin
                  failures++;
                  if (failures <= 10) begin
                     $display("mismatch %0d at result %0d: expected class %0d score %0d",
                              failures, results_seen, want.scene_class,
                              want.score_out,
                              " state %0d event %0d/%0d totals %0d/%0d/%0d at %h",
                              want.presence_state, want.event_kind, want.ev_score_out,
                              want.transitions, want.detected_events, want.lost_events,
                              want.last_transition_time);
                     $display("   actual class %0d score %0d",
                              rsp_data.scene_class, rsp_data.score_out,
                              " state %0d event %0d/%0d totals %0d/%0d/%0d at %h",
                              rsp_data.presence_state, rsp_data.event_kind,
                              rsp_data.ev_score_out, rsp_data.transitions,
                              rsp_data.detected_events, rsp_data.lost_events,
                              rsp_data.last_transition_time);
                  end
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DETECT_SCORE:       cfg.detect_score       = csr_wdata[6:0];
               CSR_STRONG_SCORE:       cfg.strong_score       = csr_wdata[6:0];
               CSR_RETAIN_WINDOW_MS:   cfg.retain_window_ms   = csr_wdata;
               CSR_DETECT_DWELL_MS:    cfg.detect_dwell_ms    = csr_wdata;
               CSR_LOST_DWELL_MS:      cfg.lost_dwell_ms      = csr_wdata;
               CSR_MIN_STABLE_SAMPLES: cfg.min_stable_samples = csr_wdata[15:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            expected_rsp_q.push_back(advance_presence(req_data));
      end
      mismatch_count <= failures;
      pending_count  <= expected_rsp_q.size();
   end

endmodule

// ===== bench/scene_presence_detector_top_tb.sv =====
// Testbench top for the scene presence detector: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module scene_presence_detector_top_tb;
   import spd_pkg::*;

   // Register indexes beyond the last register; writes to them must be ignored.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam int HOLD_OFF_CYCLES  = 400;
   localparam int RANDOM_PHASES    = 14;
   localparam int RANDOM_ITEMS     = 1750;
   localparam int DRAIN_LIMIT      = 5000;
   localparam int SETTLE_CYCLES    = 8;

   typedef enum logic [1:0] {
      EP_STRONG  = 2'd0,
      EP_WEAK    = 2'd1,
      EP_FLICKER = 2'd2,
      EP_NOISE   = 2'd3
   } episode_kind_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   spd_req_type            req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   spd_rsp_type            rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int mismatch_count;
   int pending_count;

   // Shared between the stimulus and the receiver: a request for one long hold-off of
   // the result channel, and a flag that suppresses all idling on both sides.
   bit hold_off_req;
   bit steady_run;

   int               sender_steady_left;
   logic [31:0]      sample_clock;
   episode_kind_type episode_kind;
   int               episode_left;

   scene_presence_detector_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // The checker watches every transaction on all three channels, keeps its own copy of
   // the configuration and the presence machine, and reports back a failure count and
   // the number of results still outstanding.
   spd_presence_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // 10 ns clock, starting low.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic spd_req_type make_sample(input logic valid, input logic [7:0] luma,
                                               input logic [7:0] contrast,
                                               input logic [7:0] motion,
                                               input logic [31:0] stamp);
      spd_req_type s;
      s.sample_valid   = valid;
      s.luma_mean      = luma;
      s.frame_contrast = contrast;
      s.motion_level   = motion;
      s.time_ms        = stamp;
      return s;
   endfunction

   // A lit, contrasty, moving scene: nearly always scores well above the usual threshold.
   function automatic spd_req_type strong_sample(input logic [31:0] stamp);
      return make_sample(1'b1, 8'($urandom_range(45, 210)), 8'($urandom_range(24, 255)),
                         8'($urandom_range(20, 255)), stamp);
   endfunction

   // Either an invalid sample with random metrics or a nearly still one.
   function automatic spd_req_type weak_sample(input logic [31:0] stamp);
      logic [31:0] bits;
      bits = $urandom;
      if (bits[0])
         return make_sample(1'b0, bits[15:8], bits[23:16], bits[31:24], stamp);
      return make_sample(1'b1, bits[15:8], bits[23:16], 8'($urandom_range(0, 5)), stamp);
   endfunction

   // Gaps between request transactions: mostly none or short, a few long, and now and
   // then a clean stretch with no gaps at all.
   function int pick_gap();
      int roll;
      if (steady_run) return 0;
      if (sender_steady_left > 0) begin
         sender_steady_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         sender_steady_left = $urandom_range(30, 120);
         return 0;
      end
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   // Draws a value that is zero or the top of its range now and then, otherwise a value
   // from the band where the presence machine actually changes state.
   function automatic logic [31:0] pick_extreme(input logic [31:0] top,
                                                input int unsigned lo, input int unsigned hi);
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return 32'd0;
      if (roll == 1) return top;
      return $urandom_range(hi, lo);
   endfunction

   function automatic spd_cfg_type random_config();
      spd_cfg_type c;
      c.detect_score       = 7'(pick_extreme(32'd127, 30, 100));
      c.strong_score       = 7'(pick_extreme(32'd127, 30, 100));
      c.retain_window_ms   = pick_extreme(32'hFFFF_FFFF, 0, 300);
      c.detect_dwell_ms    = pick_extreme(32'hFFFF_FFFF, 0, 80);
      c.lost_dwell_ms      = pick_extreme(32'hFFFF_FFFF, 0, 400);
      c.min_stable_samples = 16'(pick_extreme(32'h0000_FFFF, 0, 5));
      return c;
   endfunction

   // Next random sample. Most samples come in episodes of strong or weak activity, or
   // strong activity with weak dropouts, so that the machine walks through candidate,
   // present and back; the rest is unrelated noise with random timestamps.
   function spd_req_type next_sample();
      int          roll;
      logic [31:0] stamp;
      if (episode_left == 0) begin
         roll = $urandom_range(0, 99);
         if (roll < 40)      episode_kind = EP_STRONG;
         else if (roll < 72) episode_kind = EP_WEAK;
         else if (roll < 90) episode_kind = EP_FLICKER;
         else                episode_kind = EP_NOISE;
         episode_left = $urandom_range(1, 14);
      end
      episode_left--;
      roll = $urandom_range(0, 99);
      if (roll < 5)       sample_clock += 32'd0;
      else if (roll < 90) sample_clock += $urandom_range(1, 40);
      else if (roll < 97) sample_clock += $urandom_range(41, 3000);
      else                sample_clock += $urandom;
      // A zero timestamp now and then, which must not count as a start time.
      stamp = ($urandom_range(0, 99) < 2) ? 32'd0 : sample_clock;
      case (episode_kind)
         EP_STRONG: return strong_sample(stamp);
         EP_WEAK:   return weak_sample(stamp);
         EP_FLICKER: begin
            roll = $urandom_range(0, 5);
            if (roll < 2) return weak_sample(stamp);
            if (roll < 3)
               return make_sample(1'b1, 8'($urandom), 8'($urandom),
                                  8'($urandom_range(0, 45)), stamp);
            return strong_sample(stamp);
         end
         default:
            return make_sample(1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                               $urandom);
      endcase
   endfunction

   // Offers one sample and returns at the falling edge after its transaction. Called at
   // a falling edge. A gap lowers valid first; without a gap valid simply stays high.
   task automatic send_sample(input spd_req_type s);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // One register write; valid stays high so that writes can follow back to back.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Writes every register. The narrow registers get random upper bits, which the block
   // must discard; a write to a spare index may be thrown in as well.
   task automatic write_config(input spd_cfg_type c, input bit with_spare);
      logic [31:0] noise;
      noise = $urandom;
      write_reg(CSR_DETECT_SCORE, {noise[31:7], c.detect_score});
      noise = $urandom;
      write_reg(CSR_STRONG_SCORE, {noise[31:7], c.strong_score});
      write_reg(CSR_RETAIN_WINDOW_MS, c.retain_window_ms);
      write_reg(CSR_DETECT_DWELL_MS, c.detect_dwell_ms);
      write_reg(CSR_LOST_DWELL_MS, c.lost_dwell_ms);
      noise = $urandom;
      write_reg(CSR_MIN_STABLE_SAMPLES, {noise[31:16], c.min_stable_samples});
      if (with_spare)
         write_reg($urandom_range(0, 1) ? CSR_SPARE_HI : CSR_SPARE_LO, $urandom);
      csr_valid <= 1'b0;
   endtask

   // Stops offering samples and waits until every predicted result has been taken.
   // Every sample gives exactly one result, so the block is idle once none is owed.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // Result channel: random stalls, mostly short with a few long runs and some clean
   // stretches, plus one long hold-off on request so that the block backs up and stalls
   // its request side while samples are still on offer.
   initial begin : receiver
      int stall_left;
      int free_left;
      int roll;
      rsp_stall  = 1'b0;
      stall_left = 0;
      free_left  = 0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            rsp_stall    <= 1'b0;
            hold_off_req = 1'b0;
         end else if (steady_run) begin
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (free_left > 0) begin
            free_left--;
            rsp_stall <= 1'b0;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 10)      free_left  = $urandom_range(40, 150);
            else if (roll < 60) free_left  = $urandom_range(0, 3);
            else if (roll < 92) stall_left = $urandom_range(1, 3);
            else                stall_left = $urandom_range(6, 40);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Absolute limit on the run, far above the slowest correct run.
   initial begin
      #10_000_000;
      $display("FAIL scene_presence_detector_top");
      $finish;
   end

   initial begin : stimulus
      spd_cfg_type cfg;
      int          phase;
      int          waited;

      reset              = 1'b1;
      req_valid          = 1'b0;
      req_data           = '0;
      csr_valid          = 1'b0;
      csr_index          = CSR_DETECT_SCORE;
      csr_wdata          = '0;
      hold_off_req       = 1'b0;
      steady_run         = 1'b0;
      sender_steady_left = 0;
      sample_clock       = 32'd0;
      episode_kind       = EP_STRONG;
      episode_left       = 0;

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Directed samples under the reset configuration, sent back to back with no idling.
      // They walk through every scene class and the edges of each threshold, detect
      // presence, lose it after the lost dwell, retain a candidate across one weak sample
      // and then drop it, detect again across the wrap of the timestamp, and show that a
      // zero timestamp is not taken as a start time.
      steady_run = 1'b1;
      send_sample(make_sample(1'b0, 8'hFF, 8'hFF, 8'hFF, 32'd0));           // invalid
      send_sample(make_sample(1'b1, 8'd0, 8'd0, 8'hFF, 32'd0));             // flat, t=0
      send_sample(make_sample(1'b1, 8'd44, 8'd255, 8'd100, 32'd5));         // dark
      send_sample(make_sample(1'b1, 8'd45, 8'd24, 8'd30, 32'd100));         // dim
      send_sample(make_sample(1'b1, 8'd89, 8'd84, 8'd31, 32'd400));         // detect
      send_sample(make_sample(1'b1, 8'd90, 8'd85, 8'd0, 32'd450));          // normal, weak
      send_sample(make_sample(1'b1, 8'd210, 8'd255, 8'd255, 32'd500));
      send_sample(make_sample(1'b1, 8'd211, 8'd17, 8'd200, 32'd600));       // flat edge
      send_sample(make_sample(1'b1, 8'd211, 8'd18, 8'd29, 32'd700));        // bright
      send_sample(make_sample(1'b1, 8'd255, 8'd23, 8'd0, 32'd800));         // absence starts
      send_sample(make_sample(1'b1, 8'd255, 8'd200, 8'd10, 32'd120800));    // lost
      send_sample(make_sample(1'b1, 8'd100, 8'd100, 8'd255, 32'd121000));   // candidate
      send_sample(make_sample(1'b1, 8'd100, 8'd30, 8'd5, 32'd121500));      // retained
      send_sample(make_sample(1'b1, 8'd100, 8'd30, 8'd5, 32'd121600));      // dropped
      send_sample(make_sample(1'b1, 8'd100, 8'd100, 8'd255, 32'd124000));
      send_sample(make_sample(1'b1, 8'd100, 8'd30, 8'd5, 32'd126600));      // window passed
      send_sample(make_sample(1'b1, 8'd150, 8'd90, 8'd50, 32'hFFFF_FF00));
      send_sample(make_sample(1'b1, 8'd150, 8'd90, 8'd50, 32'h0000_0040));  // detect, wrap
      send_sample(make_sample(1'b0, 8'd0, 8'd0, 8'd0, 32'h0000_0100));
      send_sample(make_sample(1'b1, 8'd128, 8'd128, 8'd128, 32'd0));
      send_sample(make_sample(1'b1, 8'd128, 8'd0, 8'd0, 32'hFFFF_FFFF));
      send_sample(make_sample(1'b1, 8'd255, 8'd255, 8'd127, 32'h8000_0000));
      steady_run = 1'b0;

      // Random phases, each under its own configuration: the reset values first, then
      // every register at zero, then every register at its top, then random settings.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_results();
         if (phase == 0)
            cfg = '{detect_score: DETECT_SCORE_RST, strong_score: STRONG_SCORE_RST,
                    retain_window_ms: RETAIN_WINDOW_MS_RST,
                    detect_dwell_ms: DETECT_DWELL_MS_RST,
                    lost_dwell_ms: LOST_DWELL_MS_RST,
                    min_stable_samples: MIN_STABLE_SAMPLES_RST};
         else if (phase == 1)
            cfg = '0;
         else if (phase == 2)
            cfg = '{detect_score: 7'd127, strong_score: 7'd127,
                    retain_window_ms: 32'hFFFF_FFFF, detect_dwell_ms: 32'hFFFF_FFFF,
                    lost_dwell_ms: 32'hFFFF_FFFF, min_stable_samples: 16'hFFFF};
         else
            cfg = random_config();
         write_config(cfg, (phase % 3) == 0);
         // Some phases start just short of the timestamp wrap, the rest anywhere.
         if ((phase % 4) == 0)
            sample_clock = 32'hFFFF_FFFF - $urandom_range(0, 2000);
         else
            sample_clock = $urandom;
         if (phase == RANDOM_PHASES / 2) hold_off_req = 1'b1;
         repeat (RANDOM_ITEMS / RANDOM_PHASES) send_sample(next_sample());
      end

      // Wait for the last results, with a limit, then wait out the settle period in case the
      // block produces a result that nobody asked for.
      req_valid <= 1'b0;
      waited = 0;
      while (pending_count != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && pending_count == 0)
         $display("PASS scene_presence_detector_top");
      else
         $display("FAIL scene_presence_detector_top");
      $finish;
   end

endmodule
